FILE: sv/fwrde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwrde_pkg: shared types and constants of the radix digit emitter
// Widths, register indexes, reset values, the state type and the digit to
// ASCII mapping used by the interfaces and the core.
// ----------------------------------------------------------------------------
package fwrde_pkg;

    // Fixed field widths of the channels and of the core's digit and count fields.
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 7;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int DIGIT_W     = 6;
    localparam int CNT_W       = 7;

    // Defaults of the core parameters.
    localparam int MAX_DIGITS_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Dividend bits consumed by the divider in one cycle.
    localparam int BITS_PER_STEP = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RADIX_RESET       = 6'd10;
    localparam logic [CFG_DATA_W-1:0] DIGIT_COUNT_RESET = 6'd8;
    localparam logic [CFG_DATA_W-1:0] RADIX_MIN         = 6'd2;
    localparam logic [CFG_DATA_W-1:0] RADIX_MAX         = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 7'd90;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SHOW,
        S_ERR
    } t_state;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] alpha;
        alpha = d - DEC_LIMIT;
        if (d < DEC_LIMIT) begin
            return CHAR_ZERO + {1'b0, d};
        end
        return CHAR_A + {1'b0, alpha};
    endfunction

endpackage
`default_nettype wire

FILE: sv/fwrde_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwrde_if: channel interfaces of the radix digit emitter
// Input value channel, digit output channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwrde_in_if;
    logic                           valid;
    logic                           ready;
    logic [fwrde_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fwrde_out_if;
    logic                           valid;
    logic                           ready;
    logic [fwrde_pkg::CHAR_W-1:0]   char_code;
    logic                           is_last;
    logic                           bad_radix;

    modport source (output valid, output char_code, output is_last, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input is_last, input bad_radix,
                    output ready);
endinterface

interface fwrde_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fwrde_pkg::CFG_INDEX_W-1:0]  index;
    logic [fwrde_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/fixed_width_radix_digit_emitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an item is accepted, then divided by the radix once per digit (N digits),
// then each digit is read from the store and shown; an output stall holds the word.
// A bad radix gives its error word in the cycle after the accept.
// Throughput: one item at a time; the shared 8-bit-per-cycle divider sets the rate.
// Reset: synchronous active-low; radix returns to 10, digit count to 8, and both
// input channels hold ready low while reset is asserted.
// ----------------------------------------------------------------------------
// fixed_width_radix_digit_emitter_core: value to fixed-width base-N digits
// Repeatedly divides the value by the radix with one shared restoring divider,
// stores the remainders, then emits them most significant first as ASCII.
// ----------------------------------------------------------------------------
module fixed_width_radix_digit_emitter_core #(
    parameter int MAX_DIGITS  = fwrde_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = fwrde_pkg::VALUE_WIDTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    fwrde_in_if.sink       i_in,
    fwrde_out_if.source    o_out,
    fwrde_cfg_if.sink      i_cfg
);

    localparam int STEP   = fwrde_pkg::BITS_PER_STEP;
    localparam int NCHUNK = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int VWP    = NCHUNK * STEP;
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DW     = fwrde_pkg::DIGIT_W;
    localparam int CW     = fwrde_pkg::CNT_W;

    fwrde_pkg::t_state r_state, n_state;

    logic [fwrde_pkg::CFG_DATA_W-1:0] r_cfg_radix;
    logic [fwrde_pkg::CFG_DATA_W-1:0] r_cfg_count;

    logic [VWP-1:0]  r_quot, n_quot;
    logic [DW-1:0]   r_rem, n_rem;
    logic [CKW-1:0]  r_chunk, n_chunk;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_last_idx, n_last_idx;
    logic [DW-1:0]   r_rd_data;
    logic [DW-1:0]   r_mem [MAX_DIGITS];

    logic [VWP-1:0]  w_val_ext;
    logic [VWP-1:0]  w_quot_shift;
    logic [STEP-1:0] w_qbits;
    logic [DW-1:0]   w_rem_step;
    logic [CW-1:0]   w_eff;
    logic [CW-1:0]   w_eff_m1;
    logic            w_bad;
    logic            w_we;
    logic            w_in_acc;
    logic            w_out_acc;

    // Zero-extend or truncate the input field to the working dividend width.
    for (genvar k = 0; k < VWP; k++) begin : g_ext
        if (k < VALUE_WIDTH && k < fwrde_pkg::VALUE_W) begin : g_bit
            assign w_val_ext[k] = i_in.value[k];
        end else begin : g_zero
            assign w_val_ext[k] = 1'b0;
        end
    end

    assign w_bad = (r_cfg_radix < fwrde_pkg::RADIX_MIN) || (r_cfg_radix > fwrde_pkg::RADIX_MAX);
    assign w_eff = ({1'b0, r_cfg_count} > CW'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                             : {1'b0, r_cfg_count};
    assign w_eff_m1 = w_eff - CW'(1);

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && (r_state == fwrde_pkg::S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = o_out.valid && o_out.ready;

    assign o_out.valid     = (r_state == fwrde_pkg::S_SHOW) || (r_state == fwrde_pkg::S_ERR);
    assign o_out.bad_radix = (r_state == fwrde_pkg::S_ERR);
    assign o_out.is_last   = (r_state == fwrde_pkg::S_ERR) || (r_idx == '0);
    assign o_out.char_code = (r_state == fwrde_pkg::S_ERR) ? '0
                                                           : fwrde_pkg::ascii_of(r_rd_data);

    // One divider step: eight restoring compare-subtract stages on the top byte.
    always_comb begin
        logic [DW:0] t;
        logic [DW:0] rad;
        rad        = {1'b0, r_cfg_radix};
        w_rem_step = r_rem;
        w_qbits    = '0;
        for (int b = STEP - 1; b >= 0; b--) begin
            t = {w_rem_step, r_quot[VWP - STEP + b]};
            if (t >= rad) begin
                t          = t - rad;
                w_qbits[b] = 1'b1;
            end
            w_rem_step = t[DW-1:0];
        end
        w_quot_shift = r_quot << STEP;
    end

    always_comb begin
        n_state    = r_state;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_chunk    = r_chunk;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        w_we       = 1'b0;
        unique case (r_state)
            fwrde_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_quot     = w_val_ext;
                    n_rem      = '0;
                    n_chunk    = '0;
                    n_idx      = '0;
                    n_last_idx = w_eff_m1[IW-1:0];
                    if (w_bad) begin
                        n_state = fwrde_pkg::S_ERR;
                    end else if (w_eff != '0) begin
                        n_state = fwrde_pkg::S_DIV;
                    end
                end
            end
            fwrde_pkg::S_DIV: begin
                n_quot  = w_quot_shift | VWP'(w_qbits);
                n_rem   = w_rem_step;
                n_chunk = r_chunk + CKW'(1);
                if (r_chunk == CKW'(NCHUNK - 1)) begin
                    // Quotient complete: store this digit and start the next one.
                    w_we    = 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    if (r_idx == r_last_idx) begin
                        n_state = fwrde_pkg::S_READ;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            fwrde_pkg::S_READ: begin
                n_state = fwrde_pkg::S_SHOW;
            end
            fwrde_pkg::S_SHOW: begin
                if (w_out_acc) begin
                    if (r_idx == '0) begin
                        n_state = fwrde_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx - IW'(1);
                        n_state = fwrde_pkg::S_READ;
                    end
                end
            end
            fwrde_pkg::S_ERR: begin
                if (w_out_acc) begin
                    n_state = fwrde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwrde_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fwrde_pkg::S_IDLE;
            r_chunk    <= '0;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_chunk    <= n_chunk;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radix <= fwrde_pkg::RADIX_RESET;
            r_cfg_count <= fwrde_pkg::DIGIT_COUNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                fwrde_pkg::REG_RADIX:       r_cfg_radix <= i_cfg.data;
                fwrde_pkg::REG_DIGIT_COUNT: r_cfg_count <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    // Digit store: written least significant first, read back in reverse.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_rem_step;
        end
        r_rd_data <= r_mem[r_idx];
    end

`ifndef ASSERT_OFF
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwrde_pkg::S_DIV) |-> (r_rem < r_cfg_radix))
        else $error("divider remainder reached the radix");

    a_no_accept_while_showing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a word is pending");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.bad_radix) |->
        ((o_out.char_code >= fwrde_pkg::CHAR_ZERO && o_out.char_code < fwrde_pkg::CHAR_A - 7'd7)
         || (o_out.char_code >= fwrde_pkg::CHAR_A && o_out.char_code <= fwrde_pkg::CHAR_Z)))
        else $error("digit code out of range");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.is_last) |=> i_in.ready)
        else $error("not ready after the last word");
`endif

endmodule
`default_nettype wire
